/* sv/ins_sort_pkg.sv */
// Package for the insertion sorter: the shared value width, controller state encoding,
// and the command/status bundles between controller and datapath.
// No dependencies.
package ins_sort_pkg;

	localparam int VALUE_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_SHIFT     = 4'b0010,
		ST_EMIT_RD   = 4'b0100,
		ST_EMIT_WAIT = 4'b1000
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic accept;    // capture incoming value; start an insertion, or mark overflow if full
		logic shift;     // move buffer[pos-1] up to buffer[pos]
		logic place;     // write the held value at buffer[pos]
		logic emit_rd;   // read buffer[k] for output
		logic emit_load; // load the output register, advance k
		logic clear;     // drop count, overflow flag and output index for a new set
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic full;      // buffer holds DEPTH values
		logic pos_zero;  // insertion point reached the bottom
		logic greater;   // stored value read back exceeds the held value
		logic held_final;// the held item closes the set
		logic last;      // the entry being emitted is the top of the set
		logic out_free;  // output register can take a result this cycle
	} status_t;

endpackage

/* sv/ins_sort_item_if.sv */
// Input channel of the insertion sorter: valid/ready with one integer and
// a final marker. Depends on ins_sort_pkg.
interface ins_sort_item_if;
	import ins_sort_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      is_final;

	modport source (output valid, output value, output is_final, input ready);
	modport sink (input valid, input value, input is_final, output ready);
endinterface

/* sv/ins_sort_result_if.sv */
// Output channel of the insertion sorter: valid/ready with one sorted
// integer and its set flags. Depends on ins_sort_pkg.
interface ins_sort_result_if;
	import ins_sort_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sorted_value;
	logic                      end_of_set;
	logic                      dropped;

	modport source (output valid, output sorted_value, output end_of_set, output dropped,
		input ready);
	modport sink (input valid, input sorted_value, input end_of_set, input dropped,
		output ready);
endinterface

/* sv/insertion_sorter.sv */
// channel  direction  payload                                 handshake
// item     in         value[31:0] signed, is_final            valid/ready
// result   out        sorted_value[31:0] signed, end_of_set,  valid/ready
//                     dropped
//
// An item is accepted, then each stored value that must move up to make room
// (at most DEPTH - 1) shifts, then the item is placed; the single read port of
// the buffer memory allows one entry to move per cycle. Each result is then read
// and loaded into the output register. Reset empties the set; buffer contents
// are not cleared. A stalled result holds only the output; new items are taken
// as soon as the last result of a set sits in the output register.
// Top level of the insertion sorter. Depends on ins_sort_pkg, the channel
// interfaces, ins_sort_ctrl and ins_sort_dp.
module insertion_sorter #(
	parameter int DEPTH = 16
) (
	input logic                clk,
	input logic                arst_n,
	ins_sort_item_if.sink      item,
	ins_sort_result_if.source  result
);
	import ins_sort_pkg::*;

	cmd_t    cmd;
	status_t status;

	ins_sort_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item.valid),
		.item_is_final (item.is_final),
		.item_ready    (item.ready),
		.status        (status),
		.cmd           (cmd)
	);

	ins_sort_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (item.value),
		.is_final     (item.is_final),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.sorted_value (result.sorted_value),
		.end_of_set   (result.end_of_set),
		.dropped      (result.dropped)
	);

	// An insertion never writes past the buffer.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.place |-> !status.full)
		else $error("insertion into a full buffer");

	// At most one of accept, shift, place, emit_rd and emit_load is raised at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.shift, cmd.place, cmd.emit_rd, cmd.emit_load}))
		else $error("conflicting datapath commands");

	// A stored item keeps the block busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && !status.full) |=> !item.ready)
		else $error("item taken during an insertion");

	// Output is loaded only when the register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!result.valid || result.ready))
		else $error("result overwritten while stalled");

endmodule

/* sv/ins_sort_ctrl.sv */
// Controller of the insertion sorter: sequences insertion and output.
// Depends on ins_sort_pkg; drives the datapath through cmd_t.
module ins_sort_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_is_final,
	output logic                   item_ready,
	input  ins_sort_pkg::status_t  status,
	output ins_sort_pkg::cmd_t     cmd
);
	import ins_sort_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					// A full buffer drops the value; a final item still starts output.
					if (!status.full) begin
						state_d = ST_SHIFT;
					end else if (item_is_final) begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_SHIFT: begin
				if (!status.pos_zero && status.greater) begin
					cmd.shift = 1'b1;
				end else begin
					cmd.place = 1'b1;
					state_d   = status.held_final ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (status.out_free) begin
					cmd.emit_load = 1'b1;
					if (status.last) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/ins_sort_dp.sv */
// Datapath of the insertion sorter: buffer memory, counters, comparator and
// output register. Depends on ins_sort_pkg; commanded by ins_sort_ctrl.
module ins_sort_dp #(
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ins_sort_pkg::cmd_t                       cmd,
	output ins_sort_pkg::status_t                    status,
	input  logic signed [ins_sort_pkg::VALUE_W-1:0]  value,
	input  logic                                     is_final,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output logic signed [ins_sort_pkg::VALUE_W-1:0]  sorted_value,
	output logic                                     end_of_set,
	output logic                                     dropped
);
	import ins_sort_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [VALUE_W-1:0] mem [DEPTH];
	logic signed [VALUE_W-1:0] rd_q;
	logic signed [VALUE_W-1:0] held_q;
	logic                      held_final_q;
	logic [CW-1:0]             fill_q;
	logic [AW-1:0]             pos_q;
	logic [AW-1:0]             k_q;
	logic                      ovf_q;
	logic                      res_valid_q;

	logic [AW-1:0]             pos_m1;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;
	logic signed [VALUE_W-1:0] wr_data;
	logic                      wr_en;

	assign pos_m1 = pos_q - AW'(1);

	// Read address for the next cycle: the entry below the insertion point, or buffer[k] for output.
	always_comb begin
		rd_addr = k_q;
		if (cmd.accept) begin
			rd_addr = AW'(fill_q - CW'(1));
		end else if (cmd.shift) begin
			rd_addr = pos_m1 - AW'(1);
		end
	end

	assign wr_en   = cmd.shift | cmd.place;
	assign wr_addr = pos_q;
	assign wr_data = cmd.shift ? rd_q : held_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			held_q       <= value;
			held_final_q <= is_final;
		end
		if (cmd.emit_load) begin
			sorted_value <= rd_q;
			end_of_set   <= status.last;
			dropped      <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				pos_q <= AW'(fill_q);
				if (status.full) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.shift) begin
				pos_q <= pos_m1;
			end
			if (cmd.place) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.emit_load) begin
				k_q <= k_q + AW'(1);
			end
			if (cmd.clear) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
				k_q    <= '0;
			end
			if (cmd.emit_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

	always_comb begin
		status.full       = (fill_q == CW'(DEPTH));
		status.pos_zero   = (pos_q == '0);
		status.greater    = (rd_q > held_q);
		status.held_final = held_final_q;
		status.last       = ((CW'(k_q) + CW'(1)) == fill_q);
		status.out_free   = !res_valid_q || res_ready;
	end

endmodule

/* bench/tb_insertion_sorter.sv */
`timescale 1ns / 100ps
// Self-checking testbench for insertion_sorter: sends sets of signed integers
// and checks every sorted result against a stable ascending sort kept here.
// Depends on ins_sort_pkg, ins_sort_item_if, ins_sort_result_if and the RTL.
module tb_insertion_sorter;
	import ins_sort_pkg::*;

	localparam int DEPTH       = 16;
	localparam int ITEM_TARGET = 130;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 3 * DEPTH + 10;

	typedef logic signed [VALUE_W-1:0] word_t;

	typedef struct {
		word_t value;
		bit    is_final;
		int    gap;
		bit    calm;
	} set_item_t;

	typedef struct {
		word_t sorted_value;
		bit    end_of_set;
		bit    dropped;
	} sorted_word_t;

	logic clk;
	logic arst_n;

	ins_sort_item_if   item_ch();
	ins_sort_result_if result_ch();

	insertion_sorter #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	set_item_t    items_to_send[$];
	sorted_word_t sorted_expected[$];

	// Local copy of the sorter's set.
	word_t sort_buf[DEPTH];
	int    sort_count;
	bit    sort_overflow;

	int  fail_count;
	int  cycle_count;
	int  items_planned;
	int  items_accepted;
	int  results_seen;
	int  sets_closed;
	int  overflow_sets;
	bit  item_taken;
	bit  result_taken;
	bit  calm;
	bit  have_next;
	int  gap_left;
	int  stall_left;
	set_item_t next_item;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// Stable insertion: the new value goes after every stored value that is
	// less than or equal to it. A final item releases the whole set.
	task automatic predict_sorted(input word_t v, input bit fin);
		int pos;
		sorted_word_t r;
		if (sort_count >= DEPTH) begin
			sort_overflow = 1'b1;
		end else begin
			pos = sort_count;
			while (pos > 0 && sort_buf[pos-1] > v) begin
				sort_buf[pos] = sort_buf[pos-1];
				pos--;
			end
			sort_buf[pos] = v;
			sort_count++;
		end
		if (fin) begin
			for (int k = 0; k < sort_count; k++) begin
				r.sorted_value = sort_buf[k];
				r.end_of_set   = (k + 1 == sort_count);
				r.dropped      = sort_overflow;
				sorted_expected.insert(sorted_expected.size(), r);
			end
			sets_closed++;
			if (sort_overflow)
				overflow_sets++;
			sort_count    = 0;
			sort_overflow = 1'b0;
		end
	endtask

	task automatic push_item(input word_t v, input bit fin, input bit quiet);
		set_item_t it;
		it.value    = v;
		it.is_final = fin;
		it.calm     = quiet;
		it.gap      = quiet ? 0 : $urandom_range(0, 3);
		items_to_send.insert(items_to_send.size(), it);
		items_planned++;
	endtask

	// Fills one set of the given size with a value pattern.
	task automatic push_set(input int size, input int pattern, input bit quiet);
		word_t v;
		word_t step;
		v    = $urandom;
		step = $urandom_range(1, 1000);
		for (int k = 0; k < size; k++) begin
			case (pattern)
				0: v = $urandom;
				1: v = v + step;
				2: v = v - step;
				3: v = $signed($urandom_range(0, 7)) - 4;
				default: begin
					case ($urandom_range(0, 3))
						0: v = 32'sh7FFF_FFFF;
						1: v = 32'sh8000_0000;
						2: v = 0;
						default: v = $urandom;
					endcase
				end
			endcase
			push_item(v, k == size - 1, quiet);
		end
	endtask

	// Sender: values change on the falling edge only.
	always @(negedge clk) begin
		logic drive_valid;
		drive_valid = item_ch.valid;
		if (!arst_n) begin
			drive_valid = 1'b0;
		end else begin
			if (item_taken) begin
				item_taken  = 1'b0;
				drive_valid = 1'b0;
			end
			if (!drive_valid) begin
				if (!have_next && items_to_send.size() > 0) begin
					next_item = items_to_send.pop_front();
					have_next = 1'b1;
					gap_left  = next_item.gap;
					calm      = next_item.calm;
				end
				if (have_next) begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						drive_valid       = 1'b1;
						have_next         = 1'b0;
						item_ch.value    <= next_item.value;
						item_ch.is_final <= next_item.is_final;
					end
				end
			end
		end
		item_ch.valid <= drive_valid;
	end

	// Receiver: may stall after each transaction; no stall follows while the item last fetched by the sender is calm.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_taken) begin
				result_taken = 1'b0;
				stall_left   = calm ? 0 : $urandom_range(0, 3);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: both channels are sampled on the rising edge.
	always @(posedge clk) begin
		sorted_word_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				predict_sorted(item_ch.value, item_ch.is_final);
				item_taken = 1'b1;
				items_accepted++;
			end
			if (result_ch.valid && result_ch.ready) begin
				result_taken = 1'b1;
				results_seen++;
				if (sorted_expected.size() == 0) begin
					log_failure($sformatf("unexpected result: value %0d last %0b dropped %0b",
						result_ch.sorted_value, result_ch.end_of_set, result_ch.dropped));
				end else begin
					want = sorted_expected.pop_front();
					if (result_ch.sorted_value !== want.sorted_value ||
						result_ch.end_of_set !== want.end_of_set ||
						result_ch.dropped !== want.dropped)
						log_failure($sformatf(
							"result %0d: expected value %0d last %0b dropped %0b, got %0d %0b %0b",
							results_seen, want.sorted_value, want.end_of_set, want.dropped,
							result_ch.sorted_value, result_ch.end_of_set, result_ch.dropped));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[insertion_sorter] ERROR");
			$finish;
		end
	end

	initial begin
		int size;
		int sel;
		item_ch.valid     = 1'b0;
		item_ch.value     = '0;
		item_ch.is_final  = 1'b0;
		result_ch.ready   = 1'b0;
		arst_n            = 1'b0;
		sort_count        = 0;
		sort_overflow     = 1'b0;
		fail_count        = 0;
		cycle_count       = 0;
		items_planned     = 0;
		items_accepted    = 0;
		results_seen      = 0;
		sets_closed       = 0;
		overflow_sets     = 0;
		item_taken        = 1'b0;
		result_taken      = 1'b0;
		calm              = 1'b0;
		have_next         = 1'b0;
		gap_left          = 0;
		stall_left        = 0;

		// Directed sets: single-value sets at both extremes, a mixed set with
		// duplicates, then a set whose final item arrives with the buffer full.
		push_item(32'sh8000_0000, 1'b1, 1'b0);
		push_item(32'sh7FFF_FFFF, 1'b1, 1'b1);
		push_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
		push_item(32'sh8000_0000, 1'b0, 1'b0);
		push_item(0, 1'b0, 1'b0);
		push_item(-1, 1'b0, 1'b0);
		push_item(1, 1'b0, 1'b0);
		push_item(-1, 1'b1, 1'b0);
		for (int k = 0; k < DEPTH + 1; k++)
			push_item(word_t'(DEPTH - k), k == DEPTH, 1'b1);

		while (items_planned < ITEM_TARGET) begin
			sel = $urandom_range(0, 9);
			if (sel <= 5)
				size = $urandom_range(1, 4);
			else if (sel == 6)
				size = $urandom_range(5, 8);
			else if (sel == 7)
				size = DEPTH;
			else if (sel == 8)
				size = $urandom_range(DEPTH + 1, DEPTH + 3);
			else
				size = $urandom_range(9, DEPTH - 1);
			push_set(size, $urandom_range(0, 4), $urandom_range(0, 4) == 0);
		end

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		while (items_to_send.size() > 0 || have_next || item_ch.valid)
			@(posedge clk);
		while (sorted_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sorted_expected.size() > 0)
			log_failure($sformatf("%0d sorted results never arrived", sorted_expected.size()));

		$display("Sent %0d integers in %0d sets, %0d of them overflowing the buffer.",
			items_accepted, sets_closed, overflow_sets);
		$display("Checked %0d sorted results, %0d failures.", results_seen, fail_count);
		if (fail_count == 0)
			$display("[insertion_sorter] OK");
		else
			$display("[insertion_sorter] ERROR");
		$finish;
	end

endmodule
